@@ hdl/ise_pkg.sv @@
// Shared constants and types of the integer sort engine.
`default_nettype none
package ise_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 16;
   localparam int unsigned VALUE_WIDTH      = 32;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage : ise_pkg
`default_nettype wire

@@ hdl/ise_channel_if.sv @@
// Valid/ready channels carrying the input and result words.
`default_nettype none
interface ise_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ise_pkg::VALUE_WIDTH-1:0] value;
   logic                                  last_item;

   modport source (output valid, output value, output last_item, input ready);
   modport sink   (input valid, input value, input last_item, output ready);
endinterface : ise_req_if

interface ise_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ise_pkg::VALUE_WIDTH-1:0] sorted_value;
   logic                                  last_result;
   logic                                  overflow;

   modport source (output valid, output sorted_value, output last_result,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_value, input last_result,
                   input overflow, output ready);
endinterface : ise_rsp_if
`default_nettype wire

@@ hdl/ise_cell.sv @@
// One cell of the insertion chain: holds one element in sorted position.
`default_nettype none
module ise_cell (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire ise_pkg::cell_ctrl_type                ctrl,
   input  wire logic signed [ise_pkg::VALUE_WIDTH-1:0] new_value,
   input  wire logic                                  prev_gt,
   input  wire logic signed [ise_pkg::VALUE_WIDTH-1:0] prev_value,
   input  wire logic                                  prev_valid,
   input  wire logic signed [ise_pkg::VALUE_WIDTH-1:0] next_value,
   input  wire logic                                  next_valid,
   output logic signed [ise_pkg::VALUE_WIDTH-1:0]      value,
   output logic                                       valid,
   output logic                                       gt
);

   logic signed [ise_pkg::VALUE_WIDTH-1:0] value_ff, value_in;
   logic                                  valid_ff, valid_in;

   // An empty cell counts as larger than any incoming word.
   assign gt = !valid_ff || (new_value < value_ff);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (ctrl.insert && gt) begin
         // The cell below also yields: its element moves up into this one.
         value_in = prev_gt ? prev_value : new_value;
         valid_in = valid_ff | prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule : ise_cell
`default_nettype wire

@@ hdl/integer_sort_engine_core.sv @@
// Top level of the integer sort engine: a chain of insertion cells and its control.
// The first result is offered in the cycle after the marked input word is taken.
// Throughput: one input word per cycle while loading; one result per cycle while draining,
// unless the result channel holds ready low. No input is taken during the drain, which is
// paced by the chain shifting towards cell zero.
// Reset empties every cell, clears the overflow flag and returns to loading.
`default_nettype none
module integer_sort_engine_core #(
   parameter int unsigned CAPACITY = ise_pkg::CAPACITY_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ise_req_if.sink     req_channel,
   ise_rsp_if.source   rsp_channel
);

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type                             state_ff, state_in;
   logic                                  dropped_ff, dropped_in;
   ise_pkg::cell_ctrl_type                ctrl;
   logic signed [ise_pkg::VALUE_WIDTH-1:0] cell_value [CAPACITY];
   logic                                  cell_valid [CAPACITY];
   logic                                  cell_gt    [CAPACITY];
   logic                                  req_fire, rsp_fire, full, final_word;

   assign full       = cell_valid[CAPACITY-1];
   assign req_fire   = req_channel.valid && req_channel.ready;
   assign rsp_fire   = rsp_channel.valid && rsp_channel.ready;
   assign final_word = !cell_valid[1];

   assign ctrl.insert = req_fire && !full;
   assign ctrl.shift  = rsp_fire;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                                  prev_gt, prev_valid, next_valid;
         logic signed [ise_pkg::VALUE_WIDTH-1:0] prev_value, next_value;

         if (i == 0) begin : g_head
            assign prev_gt    = 1'b0;
            assign prev_valid = 1'b1;
            assign prev_value = req_channel.value;
         end else begin : g_body
            assign prev_gt    = cell_gt[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_value = cell_value[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_value = cell_value[i];
         end else begin : g_link
            assign next_valid = cell_valid[i+1];
            assign next_value = cell_value[i+1];
         end

         ise_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .new_value  (req_channel.value),
            .prev_gt    (prev_gt),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .gt         (cell_gt[i])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (full) begin
                  dropped_in = 1'b1;
               end
               if (req_channel.last_item) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_fire && final_word) begin
               state_in   = ST_LOAD;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in   = ST_LOAD;
            dropped_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

   assign req_channel.ready        = (state_ff == ST_LOAD);
   assign rsp_channel.valid        = (state_ff == ST_DRAIN) && cell_valid[0];
   assign rsp_channel.sorted_value = cell_value[0];
   assign rsp_channel.last_result  = final_word;
   assign rsp_channel.overflow     = dropped_ff;

endmodule : integer_sort_engine_core
`default_nettype wire

@@ tb/sv/integer_sort_engine_core_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard of the integer sort engine: predicts every sorted set and checks each result word.
module integer_sort_engine_core_checker #(
   parameter int unsigned CAPACITY = ise_pkg::CAPACITY_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ise_req_if          req_channel,
   ise_rsp_if          rsp_channel,
   output int unsigned failures,
   output int unsigned pending,
   output int unsigned results_seen
);

   typedef logic signed [ise_pkg::VALUE_WIDTH-1:0] element_type;

   typedef struct packed {
      element_type sorted_value;
      logic        last_result;
      logic        overflow;
   } sorted_word_type;

   element_type     held_elements [CAPACITY];
   int unsigned     held_count;
   logic            set_overflowed;
   sorted_word_type sorted_words_due [$];

   task automatic release_sorted_set();
      element_type swap;
      int unsigned i;
      int unsigned j;
      // Each outer pass bubbles the smallest remaining element down to position i.
      for (i = 0; i + 1 < held_count; i++) begin
         for (j = held_count - 1; j > i; j--) begin
            if (held_elements[j-1] > held_elements[j]) begin
               swap               = held_elements[j-1];
               held_elements[j-1] = held_elements[j];
               held_elements[j]   = swap;
            end
         end
      end
      for (i = 0; i < held_count; i++) begin
         sorted_words_due.push_back('{sorted_value: held_elements[i],
                                      last_result:  (i + 1 == held_count),
                                      overflow:     set_overflowed});
      end
      held_count     = 0;
      set_overflowed = 1'b0;
   endtask

   always @(posedge clock) begin
      sorted_word_type due;
      if (reset) begin
         held_count     = 0;
         set_overflowed = 1'b0;
         failures       = 0;
         results_seen   = 0;
         sorted_words_due.delete();
      end else begin
         if (rsp_channel.valid === 1'b1 && rsp_channel.ready === 1'b1) begin
            results_seen++;
            if (sorted_words_due.size() == 0) begin
               failures++;
               $display("%0t: unexpected result word: value %0d last %0b overflow %0b",
                        $time, rsp_channel.sorted_value, rsp_channel.last_result,
                        rsp_channel.overflow);
            end else begin
               due = sorted_words_due.pop_front();
               if (due.sorted_value !== rsp_channel.sorted_value ||
                   due.last_result !== rsp_channel.last_result ||
                   due.overflow !== rsp_channel.overflow) begin
                  failures++;
                  $display("%0t: result word mismatch: expected value %0d last %0b overflow %0b",
                           $time, due.sorted_value, due.last_result, due.overflow);
                  $display("%0t:                       got      value %0d last %0b overflow %0b",
                           $time, rsp_channel.sorted_value, rsp_channel.last_result,
                           rsp_channel.overflow);
               end
            end
         end
         if (req_channel.valid === 1'b1 && req_channel.ready === 1'b1) begin
            // A full store drops the word, the marked one included, and flags the whole set.
            if (held_count < CAPACITY) begin
               held_elements[held_count] = req_channel.value;
               held_count++;
            end else begin
               set_overflowed = 1'b1;
            end
            if (req_channel.last_item) begin
               release_sorted_set();
            end
         end
      end
      pending = sorted_words_due.size();
   end

endmodule : integer_sort_engine_core_checker

@@ tb/sv/integer_sort_engine_core_tb.sv @@
`timescale 1ns / 100ps
// Top of the integer sort engine testbench: clock, reset, set stimulus, result pacing and verdict.
module integer_sort_engine_core_tb;

   localparam int unsigned CAPACITY      = ise_pkg::CAPACITY_DEFAULT;
   localparam int unsigned RANDOM_WORDS  = 84;
   localparam int unsigned SETTLE_CYCLES = 2 * CAPACITY + 8;

   typedef logic signed [ise_pkg::VALUE_WIDTH-1:0] element_type;
   typedef enum int unsigned {SPREAD_FULL, SPREAD_NARROW, SPREAD_EXTREME} value_spread_type;

   localparam element_type VALUE_MIN = {1'b1, {(ise_pkg::VALUE_WIDTH-1){1'b0}}};
   localparam element_type VALUE_MAX = ~VALUE_MIN;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned failures;
   int unsigned pending;
   int unsigned results_seen;

   element_type set_words [$];
   int unsigned send_quiet_left;
   int unsigned words_sent;
   int unsigned sets_sent;
   int unsigned overflow_sets;

   ise_req_if req_bus ();
   ise_rsp_if rsp_bus ();

   always #5 clock = ~clock;

   integer_sort_engine_core #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus)
   );

   integer_sort_engine_core_checker #(
      .CAPACITY (CAPACITY)
   ) sort_checker (
      .clock        (clock),
      .reset        (reset),
      .req_channel  (req_bus),
      .rsp_channel  (rsp_bus),
      .failures     (failures),
      .pending      (pending),
      .results_seen (results_seen)
   );

   // Mostly random gaps between words, with the odd stretch of back-to-back words.
   function automatic int unsigned draw_gap(inout int unsigned quiet_left);
      int unsigned gap;
      gap = 0;
      if (quiet_left != 0) begin
         quiet_left--;
      end else if ($urandom_range(0, 9) == 0) begin
         quiet_left = $urandom_range(8, 24);
      end else begin
         gap = $urandom_range(0, 15);
      end
      return gap;
   endfunction

   // Called and returns at a falling edge; valid stays high when the next word follows at once.
   task automatic send_word(input element_type value, input logic last);
      int unsigned gap;
      gap = draw_gap(send_quiet_left);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.value     <= value;
      req_bus.last_item <= last;
      req_bus.valid     <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_queued_set();
      int unsigned idx;
      for (idx = 0; idx < set_words.size(); idx++) begin
         send_word(set_words[idx], idx + 1 == set_words.size());
      end
      sets_sent++;
      if (set_words.size() > CAPACITY) begin
         overflow_sets++;
      end
      set_words.delete();
   endtask

   initial begin : result_acceptor
      int unsigned stall;
      int unsigned quiet_left;
      quiet_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         stall = draw_gap(quiet_left);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
      end
   end

   initial begin : stimulus
      int unsigned      set_size;
      int unsigned      idx;
      int unsigned      random_start;
      int signed        magnitude;
      value_spread_type spread;
      element_type      value;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.value     <= '0;
      req_bus.last_item <= 1'b0;
      send_quiet_left = 0;
      words_sent      = 0;
      sets_sent       = 0;
      overflow_sets   = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // A set of one word, then the extremes with a repeated value.
      set_words = '{VALUE_MIN};
      send_queued_set();
      set_words = '{VALUE_MAX, element_type'(0), element_type'(-1), VALUE_MIN,
                    element_type'(0), element_type'(1)};
      send_queued_set();
      // The store fills exactly, so the marked word itself is the one dropped.
      for (idx = 0; idx < CAPACITY; idx++) begin
         magnitude = idx * 977;
         set_words.push_back(idx == 0 ? VALUE_MAX :
                             (idx[0] ? element_type'(-magnitude) : element_type'(magnitude)));
      end
      set_words.push_back(VALUE_MIN);
      send_queued_set();

      random_start = words_sent;
      while (words_sent - random_start < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0:       set_size = CAPACITY;
            1:       set_size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
            default: set_size = $urandom_range(1, 12);
         endcase
         spread = value_spread_type'($urandom_range(0, 2));
         for (idx = 0; idx < set_size; idx++) begin
            case (spread)
               SPREAD_FULL: begin
                  value = element_type'($urandom);
               end
               SPREAD_NARROW: begin
                  // A narrow range makes equal values likely.
                  value = element_type'($urandom_range(0, 15)) - 8;
               end
               default: begin
                  case ($urandom_range(0, 4))
                     0:       value = VALUE_MIN;
                     1:       value = VALUE_MAX;
                     2:       value = element_type'(-1);
                     3:       value = element_type'(0);
                     default: value = element_type'($urandom);
                  endcase
               end
            endcase
            set_words.push_back(value);
         end
         send_queued_set();
      end
      req_bus.valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Run covered %0d sets of %0d words in all, %0d of them overflowing the store.",
               sets_sent, words_sent, overflow_sets);
      $display("%0d sorted words were returned and checked.", results_seen);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule : integer_sort_engine_core_tb
